### src/mic_pkg.sv
// Package for the masked interrupt controller: register codes, group bases and encoders.
`timescale 1ns / 1ps

package mic_pkg;

    // Register index codes
    localparam logic [3:0] REG_SUMMARY   = 4'd0;
    localparam logic [3:0] REG_PEND_LOW  = 4'd1;
    localparam logic [3:0] REG_PEND_HIGH = 4'd2;
    localparam logic [3:0] REG_FIQ       = 4'd3;
    localparam logic [3:0] REG_EN_LOW    = 4'd4;
    localparam logic [3:0] REG_EN_HIGH   = 4'd5;
    localparam logic [3:0] REG_EN_BASIC  = 4'd6;
    localparam logic [3:0] REG_DIS_LOW   = 4'd7;
    localparam logic [3:0] REG_DIS_HIGH  = 4'd8;
    localparam logic [3:0] REG_DIS_BASIC = 4'd9;

    // Access modes
    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // Summary register flag bits
    localparam int SUM_GROUP0_BIT = 8;
    localparam int SUM_GROUP1_BIT = 9;

    // Source number bases of group 1 and the basic group
    localparam logic [6:0] GROUP1_BASE = 7'd32;
    localparam logic [6:0] BASIC_BASE  = 7'd64;

    // Highest set bit of a 32-bit word, 0 when empty
    function automatic logic [4:0] top_bit32(input logic [31:0] v);
        logic [4:0] n;
        n = '0;
        for (int k = 0; k < 32; k++) begin
            if (v[k]) begin
                n = 5'(k);
            end
        end
        return n;
    endfunction

    // Highest set bit of an 8-bit word, 0 when empty
    function automatic logic [2:0] top_bit8(input logic [7:0] v);
        logic [2:0] n;
        n = '0;
        for (int k = 0; k < 8; k++) begin
            if (v[k]) begin
                n = 3'(k);
            end
        end
        return n;
    endfunction

endpackage

### src/masked_interrupt_controller_unit.sv
// Masked interrupt controller, 72 level sources: top level.
`timescale 1ns / 1ps

//  Channel | Direction | Handshake                     | Payload
//  --------+-----------+-------------------------------+---------------------------------------
//  in      | to block  | i_in_valid / o_in_ready       | i_mode, i_reg_index, i_write_data,
//          |           |                               | i_lines_low, i_lines_high, i_lines_basic
//  out     | from block| o_out_valid / i_out_ready     | o_read_data, o_irq_request,
//          |           |                               | o_next_source, o_next_valid
//
//  One beat per cycle sustained while the output is not stalled. A beat lands in the
//  input register, then masking, register access and priority encoding run in one
//  pass into the result register, where the enable masks are updated too.
//  Reset (i_rst_n low, synchronous) clears both valid flags and all enable masks.
//  A stall on the output holds the result register and the input register; the
//  input side stays ready while the input register is empty.

module masked_interrupt_controller_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_mode,
    input  logic [3:0]  i_reg_index,
    input  logic [31:0] i_write_data,
    input  logic [31:0] i_lines_low,
    input  logic [31:0] i_lines_high,
    input  logic [7:0]  i_lines_basic,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_read_data,
    output logic        o_irq_request,
    output logic [6:0]  o_next_source,
    output logic        o_next_valid
);

    // Input register
    logic        r_s1_valid;
    logic        r_mode;
    logic [3:0]  r_reg_index;
    logic [31:0] r_write_data;
    logic [31:0] r_lines_low;
    logic [31:0] r_lines_high;
    logic [7:0]  r_lines_basic;

    // Enable masks
    logic [31:0] r_en_low,   n_en_low;
    logic [31:0] r_en_high,  n_en_high;
    logic [7:0]  r_en_basic, n_en_basic;

    // Result register
    logic        r_out_valid;
    logic [31:0] r_read_data,  n_read_data;
    logic [6:0]  r_next_source, n_next_source;
    logic        r_next_valid,  n_next_valid;

    logic        w_advance;
    logic [31:0] w_pend_low_old, w_pend_high_old;
    logic [7:0]  w_pend_basic_old;
    logic [31:0] w_pend_low, w_pend_high;
    logic [7:0]  w_pend_basic;

    // Move the input beat into the result register when that register frees up
    assign w_advance  = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || w_advance;

    // Read side sees the masks as they stand before this beat's write
    assign w_pend_low_old   = r_lines_low   & r_en_low;
    assign w_pend_high_old  = r_lines_high  & r_en_high;
    assign w_pend_basic_old = r_lines_basic & r_en_basic;

    always_comb begin
        n_read_data = '0;
        if (r_mode == mic_pkg::MODE_READ) begin
            case (r_reg_index) inside
                mic_pkg::REG_SUMMARY: begin
                    n_read_data = {24'd0, w_pend_basic_old};
                    n_read_data[mic_pkg::SUM_GROUP0_BIT] = |w_pend_low_old;
                    n_read_data[mic_pkg::SUM_GROUP1_BIT] = |w_pend_high_old;
                end
                mic_pkg::REG_PEND_LOW:  n_read_data = w_pend_low_old;
                mic_pkg::REG_PEND_HIGH: n_read_data = w_pend_high_old;
                mic_pkg::REG_EN_LOW, mic_pkg::REG_DIS_LOW: n_read_data = r_en_low;
                mic_pkg::REG_EN_HIGH, mic_pkg::REG_DIS_HIGH: n_read_data = r_en_high;
                mic_pkg::REG_EN_BASIC, mic_pkg::REG_DIS_BASIC: begin
                    n_read_data = {24'd0, r_en_basic};
                end
                default: n_read_data = '0;  // fiq and unused indexes read as zero
            endcase
        end
    end

    // Set or clear enables; basic bank keeps the low byte only
    always_comb begin
        n_en_low   = r_en_low;
        n_en_high  = r_en_high;
        n_en_basic = r_en_basic;
        if (r_mode == mic_pkg::MODE_WRITE) begin
            case (r_reg_index)
                mic_pkg::REG_EN_LOW:    n_en_low   = r_en_low | r_write_data;
                mic_pkg::REG_EN_HIGH:   n_en_high  = r_en_high | r_write_data;
                mic_pkg::REG_EN_BASIC:  n_en_basic = r_en_basic | r_write_data[7:0];
                mic_pkg::REG_DIS_LOW:   n_en_low   = r_en_low & ~r_write_data;
                mic_pkg::REG_DIS_HIGH:  n_en_high  = r_en_high & ~r_write_data;
                mic_pkg::REG_DIS_BASIC: n_en_basic = r_en_basic & ~r_write_data[7:0];
                default: ;  // fiq and unused indexes ignore writes
            endcase
        end
    end

    // Dispatch uses the masks after this beat's write
    assign w_pend_low   = r_lines_low   & n_en_low;
    assign w_pend_high  = r_lines_high  & n_en_high;
    assign w_pend_basic = r_lines_basic & n_en_basic;

    // Lowest group first, highest bit within the group
    always_comb begin
        n_next_source = '0;
        n_next_valid  = 1'b1;
        if (|w_pend_low) begin
            n_next_source = {2'b00, mic_pkg::top_bit32(w_pend_low)};
        end else if (|w_pend_high) begin
            n_next_source = mic_pkg::GROUP1_BASE | {2'b00, mic_pkg::top_bit32(w_pend_high)};
        end else if (|w_pend_basic) begin
            n_next_source = mic_pkg::BASIC_BASE | {4'b0000, mic_pkg::top_bit8(w_pend_basic)};
        end else begin
            n_next_valid = 1'b0;
        end
    end

    // Control state and enables
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_en_low    <= '0;
            r_en_high   <= '0;
            r_en_basic  <= '0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_en_low    <= n_en_low;
                r_en_high   <= n_en_high;
                r_en_basic  <= n_en_basic;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_mode        <= i_mode;
            r_reg_index   <= i_reg_index;
            r_write_data  <= i_write_data;
            r_lines_low   <= i_lines_low;
            r_lines_high  <= i_lines_high;
            r_lines_basic <= i_lines_basic;
        end
        if (w_advance) begin
            r_read_data   <= n_read_data;
            r_next_source <= n_next_source;
            r_next_valid  <= n_next_valid;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_data   = r_read_data;
    assign o_irq_request = r_next_valid;
    assign o_next_source = r_next_source;
    assign o_next_valid  = r_next_valid;

endmodule

### src/mic_checker.sv
// Port-level checks for the masked interrupt controller, bound to its top level.
`timescale 1ns / 1ps

module mic_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_read_data,
    input logic        o_irq_request,
    input logic [6:0]  o_next_source,
    input logic        o_next_valid
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_data)
            && $stable(o_next_source) && $stable(o_next_valid))
        else $error("result beat changed under stall");

    // Request line and dispatch valid agree
    a_irq_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_irq_request == o_next_valid)
        else $error("irq_request differs from next_valid");

    // No pending source reports source zero
    a_idle_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_next_valid |-> o_next_source == 7'd0)
        else $error("next_source nonzero with nothing pending");

    // Dispatched source lies within the 72 sources
    a_source_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_next_valid |-> o_next_source <= 7'd71)
        else $error("next_source out of range");

    // Reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind masked_interrupt_controller_unit mic_checker u_mic_checker (.*);
